>>> rtl/core/ppm_sd_pkg.sv
// Shared types, codes and reset values for the PPM-sum channel decoder.
package ppm_sd_pkg;

  localparam int DEF_CHANNELS = 8;

  localparam logic [15:0] DEF_SYNC_THRESHOLD = 16'd8000;
  localparam logic [15:0] DEF_TIMER_RELOAD   = 16'd60000;
  localparam logic [3:0]  DEF_MIN_CHANNELS   = 4'd4;
  localparam logic [14:0] DEF_PULSE_MIN      = 15'd900;
  localparam logic [14:0] DEF_PULSE_MAX      = 15'd2100;
  localparam logic [6:0]  DEF_TIMEOUT_MS     = 7'd50;
  localparam logic [6:0]  ELAPSED_MAX        = 7'd127;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_THRESHOLD = 3'd0,
    REG_TIMER_RELOAD   = 3'd1,
    REG_MIN_CHANNELS   = 3'd2,
    REG_PULSE_MIN      = 3'd3,
    REG_PULSE_MAX      = 3'd4,
    REG_TIMEOUT_MS     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_CAPTURE  = 2'd0,
    ACT_TICK     = 2'd1,
    ACT_READ     = 2'd2,
    ACT_OVERRIDE = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    CMD_CAPTURE = 3'd0,
    CMD_EDGE    = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_READ    = 3'd3,
    CMD_OVR     = 3'd4,
    CMD_NOP     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_CLEAR = 2'b10
  } bk_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] count;
    logic [3:0]  ch;
    logic [11:0] ovr;
  } q_entry_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } bk_stat_t;

endpackage

>>> rtl/core/ppm_sd_front.sv
// Front end: classify input words and hold them in a two-entry queue.
module ppm_sd_front import ppm_sd_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // capture_count[15:0], overcapture[16], channel[20:17], override_value[33:21]
  input  logic [IN_DATA_W-1:0] in_tdata,
  // action[1:0]
  input  logic [1:0]           in_tuser,
  output logic                 q_valid,
  output q_entry_t             q_entry,
  input  logic                 q_pop
);

  q_entry_t    mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        push;
  logic        ch_ok;
  logic [12:0] ov;
  q_entry_t    cls;

  assign ov    = in_tdata[33:21];
  assign ch_ok = {1'b0, in_tdata[20:17]} < 5'(CHANNELS);

  always_comb begin
    cls.count = in_tdata[15:0];
    cls.ch    = in_tdata[20:17];
    cls.ovr   = ov[11:0];
    unique case (act_t'(in_tuser))
      ACT_CAPTURE:  cls.cmd = in_tdata[16] ? CMD_EDGE : CMD_CAPTURE;
      ACT_TICK:     cls.cmd = CMD_TICK;
      ACT_READ:     cls.cmd = ch_ok ? CMD_READ : CMD_NOP;
      ACT_OVERRIDE: cls.cmd = (!ov[12] && ch_ok) ? CMD_OVR : CMD_NOP;
      default:      cls.cmd = CMD_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_entry   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/ppm_sd_back.sv
// Back end: channel state, frame handling, reads, overrides and the output register.
module ppm_sd_back import ppm_sd_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_valid,
  input  q_entry_t              q_entry,
  output bk_stat_t              stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);

  logic [15:0] sync_r;
  logic [15:0] reload_r;
  logic [3:0]  min_r;
  logic [14:0] pmin_r;
  logic [14:0] pmax_r;
  logic [6:0]  timeout_r;

  logic [15:0] widths_r [CHANNELS];
  logic [11:0] ovr_r    [CHANNELS];

  logic [15:0]     prev_r,    prev_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [CNT_W-1:0] valid_r,  valid_nxt;
  logic [CNT_W-1:0] clr_r,    clr_nxt;
  logic [6:0]      elapsed_r, elapsed_nxt;
  bk_state_t       state_r,   state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic            pop;
  logic [CH_W-1:0] ch_idx;
  logic [15:0]     diff;
  logic [15:0]     width;
  logic            is_sync;
  logic            cnt_ge_min;
  logic            cnt_full;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] clr_inc;
  logic [7:0]      elapsed_inc;
  logic [14:0]     half;
  logic [14:0]     p_hi;
  logic [14:0]     p_lo;
  logic [14:0]     rd_val;
  logic [14:0]     rv;
  logic            acc;
  logic            w_en;
  logic [CH_W-1:0] w_idx;
  logic [15:0]     w_data;
  logic            o_en;
  logic [4:0]      vc5;

  assign pop    = (state_r == ST_RUN) && q_valid && (!out_valid_r || out_tready);
  assign ch_idx = q_entry.ch[CH_W-1:0];

  assign diff       = q_entry.count - prev_r;
  assign width      = (q_entry.count < prev_r) ? (diff + reload_r) : diff;
  assign is_sync    = width > sync_r;
  assign cnt_ge_min = 32'(cnt_r) >= 32'(min_r);
  assign cnt_full   = (cnt_r == CNT_W'(CHANNELS));
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign clr_inc    = clr_r + CNT_W'(1);
  assign elapsed_inc = {1'b0, elapsed_r} + 8'd1;

  assign half   = widths_r[ch_idx][15:1];
  assign p_hi   = (half > pmax_r) ? pmax_r : half;
  assign p_lo   = (p_hi < pmin_r) ? pmin_r : p_hi;
  assign rd_val = (ovr_r[ch_idx] != 12'd0) ? {3'd0, ovr_r[ch_idx]} : p_lo;

  always_comb begin
    prev_nxt    = prev_r;
    cnt_nxt     = cnt_r;
    valid_nxt   = valid_r;
    clr_nxt     = clr_r;
    elapsed_nxt = elapsed_r;
    state_nxt   = state_r;
    rv          = '0;
    acc         = 1'b0;
    w_en        = 1'b0;
    w_idx       = cnt_r[CH_W-1:0];
    w_data      = width;
    o_en        = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        if (pop) begin
          case (q_entry.cmd)
            CMD_CAPTURE: begin
              elapsed_nxt = '0;
              prev_nxt    = q_entry.count;
              if (is_sync) begin
                if (cnt_ge_min) begin
                  valid_nxt = cnt_r;
                  if (!cnt_full) begin
                    state_nxt = ST_CLEAR;
                    clr_nxt   = cnt_r;
                  end
                end
                cnt_nxt = '0;
              end else if (!cnt_full) begin
                w_en    = 1'b1;
                cnt_nxt = cnt_inc;
                if (cnt_inc == CNT_W'(CHANNELS)) begin
                  valid_nxt = CNT_W'(CHANNELS);
                end
              end
            end
            CMD_EDGE: elapsed_nxt = '0;
            CMD_TICK: begin
              if (elapsed_inc > {1'b0, timeout_r}) begin
                valid_nxt = '0;
              end
              elapsed_nxt = elapsed_inc[7] ? ELAPSED_MAX : elapsed_inc[6:0];
            end
            CMD_READ: rv = rd_val;
            CMD_OVR: begin
              o_en = 1'b1;
              if (q_entry.ovr != 12'd0) begin
                valid_nxt = CNT_W'(1);
                acc       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        w_en    = 1'b1;
        w_idx   = clr_r[CH_W-1:0];
        w_data  = '0;
        clr_nxt = clr_inc;
        if (clr_inc == CNT_W'(CHANNELS)) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  assign vc5 = 5'(valid_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'd0, acc, (valid_nxt != '0), vc5[3:0], rv};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= DEF_SYNC_THRESHOLD;
      reload_r    <= DEF_TIMER_RELOAD;
      min_r       <= DEF_MIN_CHANNELS;
      pmin_r      <= DEF_PULSE_MIN;
      pmax_r      <= DEF_PULSE_MAX;
      timeout_r   <= DEF_TIMEOUT_MS;
      prev_r      <= '0;
      cnt_r       <= '0;
      valid_r     <= '0;
      clr_r       <= '0;
      elapsed_r   <= '0;
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        widths_r[i] <= '0;
        ovr_r[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_THRESHOLD: sync_r    <= cfg_wdata;
          REG_TIMER_RELOAD:   reload_r  <= cfg_wdata;
          REG_MIN_CHANNELS:   min_r     <= cfg_wdata[3:0];
          REG_PULSE_MIN:      pmin_r    <= cfg_wdata[14:0];
          REG_PULSE_MAX:      pmax_r    <= cfg_wdata[14:0];
          REG_TIMEOUT_MS:     timeout_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      prev_r      <= prev_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      clr_r       <= clr_nxt;
      elapsed_r   <= elapsed_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (w_en) begin
        widths_r[w_idx] <= w_data;
      end
      if (o_en) begin
        ovr_r[ch_idx] <= q_entry.ovr;
      end
    end
  end

  assign stat.clearing = (state_r == ST_CLEAR);
  assign stat.pop      = pop;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule

>>> rtl/core/ppm_sum_channel_decoder_top.sv
// PPM-sum channel decoder top level: front queue, back end and checks.
//
// Input channel in_*: one word per event (capture edge, millisecond tick,
// channel read or override write), kind in in_tuser. Output channel out_*:
// exactly one word per input word, in order, with the read width, the
// published channel count and the override-accepted flag.
// cfg_*: register writes take effect at the clock edge with cfg_we high.
// An accepted word passes through the queue and then the output register
// before out_tvalid. Throughput is one word per cycle when nothing stalls,
// set by the single back-end execute stage. A sync capture that publishes a
// frame short of CHANNELS slots stalls the back end while it zeroes the unused
// slots; the two-word queue keeps accepting input until it is full.
// Synchronous reset (rst_n low) loads the register defaults, zeroes all
// channel widths, overrides and counters and empties queue and output.
// When the receiver holds out_tready low, out_tvalid and out_tdata hold,
// the back end stops and in_tready drops once the queue is full.
module ppm_sum_channel_decoder_top import ppm_sd_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // capture_count[15:0], overcapture[16], channel[20:17], override_value[33:21]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_value[14:0], valid_count[18:15], link_up[19], override_accepted[20]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic     q_valid;
  q_entry_t q_entry;
  bk_stat_t stat;

  ppm_sd_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (stat.pop)
  );

  ppm_sd_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !stat.pop)
    else $error("queue popped during slot clearing");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_override_sets_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[20]) |-> (out_tdata[18:15] == 4'd1) && out_tdata[19])
    else $error("accepted override did not publish one channel");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output word valid after reset");
`endif

endmodule
